@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL modules; lzss_back is the one user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

@@ rtl/core/lzss_pkg.sv @@
// Shared types and constants of the LZSS token stream decoder.
`timescale 1ns / 1ps
package lzss_pkg;
   localparam int HISTORY_DEPTH_DEFAULT = 8192;
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_LEN = 15;
   localparam int DIST_W = 13;
   localparam logic [DIST_W-1:0] DIST_BIAS = DIST_W'(MAX_LEN);

   localparam logic [7:0] TAG_ONE_LIT = 8'h80;
   localparam logic [7:0] TAG_RUN = 8'h00;

   localparam int CSR_AW = 3;
   localparam logic CSR_IDX_OUTPUT_LIMIT = 1'b0;

   typedef struct packed {
      logic        is_copy;
      logic [15:0] data;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_burst;
      logic       bad_reference;
      logic       limit_reached;
   } rsp_type;
endpackage

@@ rtl/core/lzss_front.sv @@
// Token parser: turns stream bytes into literal and copy commands.
`timescale 1ns / 1ps
module lzss_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         in_byte,
   input  logic               end_of_input,
   input  logic               queue_full,
   output logic               push,
   output lzss_pkg::cmd_type  push_cmd
);
   localparam logic [2:0] PH_TAG     = 3'd0;
   localparam logic [2:0] PH_ONE_LIT = 3'd1;
   localparam logic [2:0] PH_COUNT   = 3'd2;
   localparam logic [2:0] PH_RUN     = 3'd3;
   localparam logic [2:0] PH_CODE_HI = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] code_lo_ff, code_lo_in;
   logic [8:0] run_ff, run_in;
   logic [8:0] run_dec;
   logic       accept;

   assign req_stall = queue_full;
   assign accept = req_valid & ~queue_full;
   assign run_dec = (run_ff != 9'd0) ? run_ff - 9'd1 : run_ff;

   always_comb begin
      phase_in = phase_ff;
      code_lo_in = code_lo_ff;
      run_in = run_ff;
      push = 1'b0;
      push_cmd.is_copy = 1'b0;
      push_cmd.data = {8'd0, in_byte};
      if (accept) begin
         unique case (phase_ff)
            PH_ONE_LIT: begin
               push = 1'b1;
               phase_in = PH_TAG;
            end
            PH_COUNT: begin
               run_in = {1'b0, in_byte} + 9'd1;
               phase_in = PH_RUN;
            end
            PH_RUN: begin
               push = 1'b1;
               run_in = run_dec;
               if (run_dec == 9'd0) begin
                  phase_in = PH_TAG;
               end
            end
            PH_CODE_HI: begin
               push = 1'b1;
               push_cmd.is_copy = 1'b1;
               push_cmd.data = {in_byte, code_lo_ff};
               code_lo_in = 8'd0;
               phase_in = PH_TAG;
            end
            default: begin
               if (in_byte == lzss_pkg::TAG_ONE_LIT) begin
                  phase_in = PH_ONE_LIT;
               end else if (in_byte == lzss_pkg::TAG_RUN) begin
                  phase_in = PH_COUNT;
               end else begin
                  code_lo_in = in_byte;
                  phase_in = PH_CODE_HI;
               end
            end
         endcase
         if (end_of_input) begin
            phase_in = PH_TAG;
            code_lo_in = 8'd0;
            run_in = 9'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         code_lo_ff <= 8'd0;
         run_ff <= 9'd0;
      end else begin
         phase_ff <= phase_in;
         code_lo_ff <= code_lo_in;
         run_ff <= run_in;
      end
   end
endmodule

@@ rtl/core/lzss_fifo.sv @@
// Short command queue between the parser and the copy engine.
`timescale 1ns / 1ps
module lzss_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lzss_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output lzss_pkg::cmd_type  head_cmd,
   output logic               empty,
   output logic               full
);
   localparam int AW = $clog2(lzss_pkg::QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(lzss_pkg::QUEUE_DEPTH - 1);
   localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(lzss_pkg::QUEUE_DEPTH);

   lzss_pkg::cmd_type q_ff [lzss_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign empty = (cnt_ff == '0);
   assign full = (cnt_ff == DEPTH_CNT);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign head_cmd = q_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ rtl/core/lzss_back.sv @@
// Copy engine: history window, output count and limit, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lzss_back #(
   parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        output_limit,
   input  lzss_pkg::cmd_type  head_cmd,
   input  logic               empty,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output lzss_pkg::rsp_type  rsp
);
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int DW = lzss_pkg::DIST_W;
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
   localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_EMIT = 2'd2;

   logic [7:0]        window_mem [HISTORY_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [31:0]       prod_ff, prod_in;
   logic [DW-1:0]     dist_ff, dist_in;
   logic [3:0]        left_ff, left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lzss_pkg::rsp_type rsp_ff, rsp_in;

   logic [DW-1:0]     head_dist;
   logic [3:0]        head_len;
   logic              head_bad, below_lim, hit_lim, out_free;
   logic [31:0]       prod_plus;
   logic [AW:0]       addr_sum;
   logic [AW-1:0]     rd_addr;
   logic              emit_valid, emit_write, emit_last, emit_bad;
   logic [7:0]        emit_byte;

   assign head_len = head_cmd.data[3:0];
   assign head_dist = DW'(head_cmd.data[15:4]) + lzss_pkg::DIST_BIAS;
   assign head_bad = (32'(head_dist) > prod_ff);
   assign below_lim = (prod_ff < output_limit);
   assign prod_plus = prod_ff + 32'd1;
   assign hit_lim = (prod_plus == output_limit);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   assign addr_sum = {1'b0, wp_ff} + DEPTH_W - (AW + 1)'(dist_ff);
   assign rd_addr = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : AW'(addr_sum);

   always_comb begin
      state_in = state_ff;
      dist_in = dist_ff;
      left_in = left_ff;
      pop = 1'b0;
      emit_valid = 1'b0;
      emit_write = 1'b0;
      emit_last = 1'b1;
      emit_bad = 1'b0;
      emit_byte = head_cmd.data[7:0];
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               if (!head_cmd.is_copy) begin
                  if (!below_lim) begin
                     pop = 1'b1;
                  end else if (out_free) begin
                     pop = 1'b1;
                     emit_valid = 1'b1;
                     emit_write = 1'b1;
                  end
               end else if (head_bad) begin
                  if (!below_lim) begin
                     pop = 1'b1;
                  end else if (out_free) begin
                     pop = 1'b1;
                     emit_valid = 1'b1;
                     emit_bad = 1'b1;
                     emit_byte = 8'd0;
                  end
               end else begin
                  pop = 1'b1;
                  if (head_len != 4'd0 && below_lim) begin
                     dist_in = head_dist;
                     left_in = head_len;
                     state_in = B_READ;
                  end
               end
            end
         end
         B_READ: begin
            state_in = B_EMIT;
         end
         B_EMIT: begin
            emit_byte = rd_data_ff;
            emit_last = (left_ff == 4'd1) | hit_lim;
            if (out_free) begin
               emit_valid = 1'b1;
               emit_write = 1'b1;
               left_in = left_ff - 4'd1;
               state_in = emit_last ? B_IDLE : B_READ;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      wp_in = wp_ff;
      prod_in = prod_ff;
      if (emit_write) begin
         wp_in = (wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1);
         prod_in = prod_plus;
      end
      rsp_valid_in = emit_valid ? 1'b1 : (rsp_valid_ff & rsp_stall);
      rsp_in = rsp_ff;
      if (emit_valid) begin
         rsp_in.out_byte = emit_byte;
         rsp_in.last_of_burst = emit_last;
         rsp_in.bad_reference = emit_bad;
         rsp_in.limit_reached = emit_write & hit_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_write) begin
         window_mem[wp_ff] <= emit_byte;
      end
      if (state_ff == B_READ) begin
         rd_data_ff <= window_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      left_ff <= left_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= B_IDLE;
         wp_ff <= '0;
         prod_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in;
         prod_ff <= prod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   `ASSERT_CHK(a_wp_step, clock, reset, emit_write |=> wp_ff != $past(wp_ff))
   `ASSERT_CHK(a_bad_zero, clock, reset, rsp_valid_ff && rsp_ff.bad_reference |-> rsp_ff.out_byte == 8'd0 && rsp_ff.last_of_burst)
   `ASSERT_NEVER(a_pop_busy, clock, reset, state_ff != B_IDLE && pop)
endmodule

@@ rtl/core/lzss_token_stream_decoder.sv @@
// Top level of the LZSS token stream decoder: CSR port, parser, queue, copy engine.
`timescale 1ns / 1ps
// The parser takes one compressed byte per cycle and queues a literal or copy
// command for each byte that produces output; it stalls only when the
// four-entry command queue is full. The copy engine pops one command per
// cycle for a literal (one result) while the output is not stalled. For a
// copy it reads and then writes the single-port history window for each
// copied byte, and takes no new command until the copy is done.
// Output stops when the byte count reaches output_limit (CSR at address 0).
module lzss_token_stream_decoder #(
   parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_end_of_input,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_burst,
   output logic                        rsp_bad_reference,
   output logic                        rsp_limit_reached,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lzss_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   logic [31:0]       limit_ff, limit_in;
   logic              limit_sel;
   logic              push, pop, q_empty, q_full;
   lzss_pkg::cmd_type push_cmd, head_cmd;
   lzss_pkg::rsp_type rsp;

   assign csr_pready = 1'b1;
   assign limit_sel = (csr_paddr[2] == lzss_pkg::CSR_IDX_OUTPUT_LIMIT);
   assign csr_prdata = limit_sel ? limit_ff : 32'd0;
   assign limit_in = (csr_psel && csr_penable && csr_pwrite && limit_sel) ?
                     csr_pwdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 32'd0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   lzss_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .queue_full   (q_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   lzss_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   lzss_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .output_limit (limit_ff),
      .head_cmd     (head_cmd),
      .empty        (q_empty),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp)
   );

   assign rsp_out_byte = rsp.out_byte;
   assign rsp_last_of_burst = rsp.last_of_burst;
   assign rsp_bad_reference = rsp.bad_reference;
   assign rsp_limit_reached = rsp.limit_reached;
endmodule
